>>> design/cbf_pkg.sv
// shared types and constants of the counting bloom filter engine
`default_nettype none

package cbf_pkg;

	// fixed field widths of the request and result beats
	localparam int IDX_W      = 12;
	localparam int LANES      = 8;
	localparam int OP_W       = 2;
	localparam int MULT_W     = 8;
	localparam int CFG_W      = 4;
	localparam int CFG_IDX_W  = 1;
	localparam int HCNT_W     = 4;
	localparam int CBITS_W    = 5;
	localparam int QUEUE_DEPTH = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_BITS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT   = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_MEMBER = 2'd2,
		OP_MULTI  = 2'd3
	} op_t;

	// raw configuration register contents
	typedef struct packed {
		logic [CFG_W-1:0] counter_bits;
		logic [CFG_W-1:0] hash_count;
	} cfg_t;

	// classified command header passed from front to back
	typedef struct packed {
		op_t                op;
		logic [HCNT_W-1:0]  hcnt;   // lanes in use, 1..max hashes
		logic [CBITS_W-1:0] cbits;  // counter width in use, 1..max bits
	} cmd_hdr_t;

	localparam int HDR_W = $bits(cmd_hdr_t);

endpackage

`default_nettype wire

>>> design/counting_bloom_filter_engine_unit.sv
// top level of the counting bloom filter engine
`default_nettype none

// counting bloom filter over NUM_COUNTERS counters held in one single-port
// memory. each request beat carries an opcode and up to eight counter
// positions (precomputed element hashes); hash_count of them are used.
// insert and delete change every selected counter by one, all or nothing,
// and report success; membership reports whether all selected counters are
// nonzero; multiplicity reports their minimum (low 8 bits). a position
// beyond the store wraps modulo NUM_COUNTERS; a position named twice in one
// request counts twice. after reset the block sweeps the memory to zero,
// one counter a cycle, and stalls requests until that pass is done. with
// n lanes in use, the back end reads the n counters, then on an applied
// update writes them back, bounded by the single memory port. the front
// end registers each request, then runs index reduction (reciprocal
// multiply, then subtract) when NUM_COUNTERS is neither a power of two
// nor at least 4096; a two-entry command queue lets it take the next
// request while the back end works, and a result register lets the back
// end go on while a result beat waits.
// configuration is written through a plain write port: index 0 counter_bits,
// index 1 hash_count; write it only while the block is idle.
module counting_bloom_filter_engine_unit #(
	parameter int NUM_COUNTERS     = 4096,
	parameter int MAX_HASHES       = 8,
	parameter int MAX_COUNTER_BITS = 8
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// configuration write port
	input  wire logic                             cfg_wr_en,
	input  wire logic [cbf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [cbf_pkg::CFG_W-1:0]        cfg_data,
	// request channel
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [cbf_pkg::OP_W-1:0]         opcode,
	input  wire logic [cbf_pkg::IDX_W-1:0]        index_0,
	input  wire logic [cbf_pkg::IDX_W-1:0]        index_1,
	input  wire logic [cbf_pkg::IDX_W-1:0]        index_2,
	input  wire logic [cbf_pkg::IDX_W-1:0]        index_3,
	input  wire logic [cbf_pkg::IDX_W-1:0]        index_4,
	input  wire logic [cbf_pkg::IDX_W-1:0]        index_5,
	input  wire logic [cbf_pkg::IDX_W-1:0]        index_6,
	input  wire logic [cbf_pkg::IDX_W-1:0]        index_7,
	// result channel
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic                                  success,
	output logic                                  member,
	output logic [cbf_pkg::MULT_W-1:0]            multiplicity
);
	import cbf_pkg::*;

	localparam int AW    = $clog2(NUM_COUNTERS);
	localparam int POS_W = MAX_HASHES * AW;
	localparam int QW    = HDR_W + POS_W;

	// configuration registers
	cfg_t cfg_q;

	// request indices gathered into lanes
	logic [IDX_W-1:0] idx [LANES];

	// front to queue
	logic             push_valid;
	logic             push_stall;
	cmd_hdr_t         push_hdr;
	logic [POS_W-1:0] push_pos;

	// queue to back
	logic             pop_valid;
	logic             pop_take;
	logic [QW-1:0]    pop_data;
	cmd_hdr_t         pop_hdr;
	logic [POS_W-1:0] pop_pos;

	// high while the memory clearing pass runs
	logic             clear_busy;

	assign idx[0] = index_0;
	assign idx[1] = index_1;
	assign idx[2] = index_2;
	assign idx[3] = index_3;
	assign idx[4] = index_4;
	assign idx[5] = index_5;
	assign idx[6] = index_6;
	assign idx[7] = index_7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.counter_bits <= CFG_W'(4);
			cfg_q.hash_count   <= CFG_W'(4);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_COUNTER_BITS: cfg_q.counter_bits <= cfg_data;
				CFG_HASH_COUNT:   cfg_q.hash_count   <= cfg_data;
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	// front: accept, clamp and reduce positions
	cbf_front #(
		.NUM_COUNTERS     (NUM_COUNTERS),
		.MAX_HASHES       (MAX_HASHES),
		.MAX_COUNTER_BITS (MAX_COUNTER_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.hold       (clear_busy),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.idx        (idx),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_hdr   (push_hdr),
		.push_pos   (push_pos)
	);

	// command queue
	cbf_queue #(
		.W (QW)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_stall (push_stall),
		.push_data  ({push_hdr, push_pos}),
		.pop_valid  (pop_valid),
		.pop_take   (pop_take),
		.pop_data   (pop_data)
	);

	assign pop_hdr = cmd_hdr_t'(pop_data[QW-1 -: HDR_W]);
	assign pop_pos = pop_data[POS_W-1:0];

	// back: memory sequencer and result register
	cbf_back #(
		.NUM_COUNTERS     (NUM_COUNTERS),
		.MAX_HASHES       (MAX_HASHES),
		.MAX_COUNTER_BITS (MAX_COUNTER_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear_busy   (clear_busy),
		.pop_valid    (pop_valid),
		.pop_take     (pop_take),
		.pop_hdr      (pop_hdr),
		.pop_pos      (pop_pos),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.success      (success),
		.member       (member),
		.multiplicity (multiplicity)
	);

endmodule

`default_nettype wire

>>> design/cbf_front.sv
// front end: accepts request beats, clamps configuration, reduces indices into the store
`default_nettype none

module cbf_front #(
	parameter int NUM_COUNTERS     = 4096,
	parameter int MAX_HASHES       = 8,
	parameter int MAX_COUNTER_BITS = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  hold,
	input  wire cbf_pkg::cfg_t                         cfg,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [cbf_pkg::OP_W-1:0]              opcode,
	input  wire logic [cbf_pkg::IDX_W-1:0]             idx [cbf_pkg::LANES],
	output logic                                       push_valid,
	input  wire logic                                  push_stall,
	output cbf_pkg::cmd_hdr_t                          push_hdr,
	output logic [MAX_HASHES*$clog2(NUM_COUNTERS)-1:0] push_pos
);
	import cbf_pkg::*;

	localparam int AW    = $clog2(NUM_COUNTERS);
	localparam int BIT_W = 1;
	// index already lies in range or a mask does the modulo
	localparam bit DIRECT = ((NUM_COUNTERS & (NUM_COUNTERS - 1)) == 0) ||
		(NUM_COUNTERS >= 2**IDX_W);
	// quotient = (idx * RECIP) >> RSH, exact over the whole index range
	localparam int     RW      = IDX_W + 2;
	localparam int     RSH     = IDX_W + AW;
	localparam longint RECIP_L = ((longint'(1) << RSH) / longint'(NUM_COUNTERS)) + longint'(1);
	localparam logic [RW-1:0]    RECIP  = RW'(RECIP_L);
	localparam logic [IDX_W-1:0] NC_IDX = IDX_W'(NUM_COUNTERS);

	typedef enum logic [2:0] {
		F_IDLE   = 3'b001,
		F_REDUCE = 3'b010,
		F_PUSH   = 3'b100
	} fstate_t;

	fstate_t            state_q;
	logic [BIT_W-1:0]   bit_q;
	cmd_hdr_t           hdr_q;
	logic [IDX_W-1:0]   idx_q [MAX_HASHES];
	logic [IDX_W-1:0]   quo_q [MAX_HASHES];
	logic [AW-1:0]      pos_q [MAX_HASHES];
	logic               acc;
	logic [HCNT_W-1:0]  hcnt;
	logic [CBITS_W-1:0] cbits;

	// quotient of an index by the store size
	function automatic logic [IDX_W-1:0] quot(input logic [IDX_W-1:0] x);
		logic [IDX_W+RW-1:0] p;
		p = (IDX_W+RW)'(x) * (IDX_W+RW)'(RECIP);
		return IDX_W'(p >> RSH);
	endfunction

	assign in_stall   = hold || (state_q != F_IDLE);
	assign acc        = in_valid && !in_stall;
	assign push_valid = (state_q == F_PUSH);
	assign push_hdr   = hdr_q;

	always_comb begin
		if (cfg.hash_count == '0) begin
			hcnt = HCNT_W'(1);
		end else if (cfg.hash_count > HCNT_W'(MAX_HASHES)) begin
			hcnt = HCNT_W'(MAX_HASHES);
		end else begin
			hcnt = cfg.hash_count;
		end
		if (cfg.counter_bits == '0) begin
			cbits = CBITS_W'(1);
		end else if (CBITS_W'(cfg.counter_bits) > CBITS_W'(MAX_COUNTER_BITS)) begin
			cbits = CBITS_W'(MAX_COUNTER_BITS);
		end else begin
			cbits = CBITS_W'(cfg.counter_bits);
		end
	end

	always_comb begin
		for (int l = 0; l < MAX_HASHES; l++) begin
			push_pos[l*AW +: AW] = pos_q[l];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			bit_q   <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (acc) begin
						bit_q   <= BIT_W'(1);
						state_q <= DIRECT ? F_PUSH : F_REDUCE;
					end
				end
				F_REDUCE: begin
					if (bit_q == '0) begin
						state_q <= F_PUSH;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				F_PUSH: begin
					if (!push_stall) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// two reduction steps: quotient, then remainder
	always_ff @(posedge clk) begin
		if (acc) begin
			hdr_q.op    <= op_t'(opcode);
			hdr_q.hcnt  <= hcnt;
			hdr_q.cbits <= cbits;
			for (int l = 0; l < MAX_HASHES; l++) begin
				idx_q[l] <= idx[l];
				pos_q[l] <= DIRECT ? AW'(idx[l]) : '0;
			end
		end else if (state_q == F_REDUCE) begin
			for (int l = 0; l < MAX_HASHES; l++) begin
				if (bit_q != '0) begin
					quo_q[l] <= quot(idx_q[l]);
				end else begin
					pos_q[l] <= AW'(idx_q[l] - IDX_W'(quo_q[l] * NC_IDX));
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> design/cbf_queue.sv
// short command queue between front and back
`default_nettype none

module cbf_queue #(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push_valid,
	output logic              push_stall,
	input  wire logic [W-1:0] push_data,
	output logic              pop_valid,
	input  wire logic         pop_take,
	output logic [W-1:0]      pop_data
);
	import cbf_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	logic [W-1:0] store_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          do_push;
	logic          do_pop;

	assign push_stall = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = store_q[rd_q];
	assign do_push    = push_valid && !push_stall;
	assign do_pop     = pop_take && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

>>> design/cbf_back.sv
// back end: counter memory, read-check-write sequencer and result register
`default_nettype none

module cbf_back #(
	parameter int NUM_COUNTERS     = 4096,
	parameter int MAX_HASHES       = 8,
	parameter int MAX_COUNTER_BITS = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	output logic                                       clear_busy,
	input  wire logic                                  pop_valid,
	output logic                                       pop_take,
	input  wire cbf_pkg::cmd_hdr_t                     pop_hdr,
	input  wire logic [MAX_HASHES*$clog2(NUM_COUNTERS)-1:0] pop_pos,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic                                       success,
	output logic                                       member,
	output logic [cbf_pkg::MULT_W-1:0]                 multiplicity
);
	import cbf_pkg::*;

	localparam int AW = $clog2(NUM_COUNTERS);
	localparam int CW = MAX_COUNTER_BITS;
	localparam int LW = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
	localparam logic [CW-1:0] ALL_ONES = '1;

	typedef enum logic [4:0] {
		B_CLEAR = 5'b00001,
		B_IDLE  = 5'b00010,
		B_READ  = 5'b00100,
		B_WRITE = 5'b01000,
		B_OUT   = 5'b10000
	} bstate_t;

	logic [CW-1:0] mem [NUM_COUNTERS];

	bstate_t        state_q;
	logic [AW-1:0]  clr_q;
	logic [LW-1:0]  iss_q;
	logic           iss_done_q;
	logic [LW-1:0]  cons_q;
	logic           rd_pend_q;
	logic [LW-1:0]  wr_q;
	logic           ok_q;
	logic           acc_member_q;
	logic [CW-1:0]  min_q;
	logic           out_valid_q;

	cmd_hdr_t       hdr_q;
	logic [AW-1:0]  pos_q [MAX_HASHES];
	logic [CW-1:0]  newv_q [MAX_HASHES];
	logic [CW-1:0]  rd_data_q;
	logic           res_success_q;
	logic           res_member_q;
	logic [MULT_W-1:0] res_mult_q;

	logic [LW-1:0]  last;
	logic [CW-1:0]  lim;
	logic           is_upd;
	logic [CW-1:0]  raw;
	logic [CW-1:0]  cur;
	logic           fail;
	logic [CW-1:0]  nval;
	logic           ok_next;
	logic           out_free;
	logic           mem_we;
	logic           mem_re;
	logic [AW-1:0]  mem_addr;
	logic [CW-1:0]  mem_wdata;

	assign last       = LW'(hdr_q.hcnt - 4'd1);
	assign lim        = ~(ALL_ONES << hdr_q.cbits);
	assign is_upd     = (hdr_q.op == OP_INSERT) || (hdr_q.op == OP_DELETE);
	assign raw        = rd_data_q & lim;
	assign out_free   = !out_valid_q || !out_stall;
	assign pop_take   = (state_q == B_IDLE) && pop_valid;
	assign clear_busy = (state_q == B_CLEAR);

	assign out_valid    = out_valid_q;
	assign success      = res_success_q;
	assign member       = res_member_q;
	assign multiplicity = res_mult_q;

	// a repeated position sees the value left by its latest earlier lane
	always_comb begin
		cur = raw;
		for (int j = 0; j < MAX_HASHES; j++) begin
			if ((LW'(j) < cons_q) && (pos_q[j] == pos_q[cons_q])) begin
				cur = newv_q[j];
			end
		end
		fail = 1'b0;
		nval = cur;
		case (hdr_q.op)
			OP_INSERT: begin
				fail = (cur >= lim);
				nval = cur + 1'b1;
			end
			OP_DELETE: begin
				fail = (cur == '0);
				nval = cur - 1'b1;
			end
			default: begin
				fail = 1'b0;
				nval = cur;
			end
		endcase
		ok_next = ok_q && !fail;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = clr_q;
		mem_wdata = '0;
		unique case (state_q)
			B_CLEAR: begin
				mem_we = 1'b1;
			end
			B_READ: begin
				mem_re   = !iss_done_q;
				mem_addr = pos_q[iss_q];
			end
			B_WRITE: begin
				mem_we    = 1'b1;
				mem_addr  = pos_q[wr_q];
				mem_wdata = newv_q[wr_q];
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_CLEAR;
			clr_q        <= '0;
			iss_q        <= '0;
			iss_done_q   <= 1'b0;
			cons_q       <= '0;
			rd_pend_q    <= 1'b0;
			wr_q         <= '0;
			ok_q         <= 1'b1;
			acc_member_q <= 1'b1;
			min_q        <= '1;
			out_valid_q  <= 1'b0;
		end else begin
			if ((state_q == B_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(NUM_COUNTERS - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (pop_valid) begin
						iss_q        <= '0;
						iss_done_q   <= 1'b0;
						cons_q       <= '0;
						rd_pend_q    <= 1'b0;
						ok_q         <= 1'b1;
						acc_member_q <= 1'b1;
						min_q        <= '1;
						state_q      <= B_READ;
					end
				end
				B_READ: begin
					rd_pend_q <= !iss_done_q;
					if (!iss_done_q) begin
						if (iss_q == last) begin
							iss_done_q <= 1'b1;
						end else begin
							iss_q <= iss_q + 1'b1;
						end
					end
					if (rd_pend_q) begin
						ok_q <= ok_next;
						if (raw == '0) begin
							acc_member_q <= 1'b0;
						end
						if (raw < min_q) begin
							min_q <= raw;
						end
						if (cons_q == last) begin
							wr_q    <= '0;
							state_q <= (is_upd && ok_next) ? B_WRITE : B_OUT;
						end else begin
							cons_q <= cons_q + 1'b1;
						end
					end
				end
				B_WRITE: begin
					if (wr_q == last) begin
						state_q <= B_OUT;
					end else begin
						wr_q <= wr_q + 1'b1;
					end
				end
				B_OUT: begin
					if (out_free) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_CLEAR;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop_take) begin
			hdr_q <= pop_hdr;
			for (int l = 0; l < MAX_HASHES; l++) begin
				pos_q[l] <= pop_pos[l*AW +: AW];
			end
		end
		if ((state_q == B_READ) && rd_pend_q) begin
			newv_q[cons_q] <= nval;
		end
		if ((state_q == B_OUT) && out_free) begin
			res_success_q <= is_upd && ok_q;
			res_member_q  <= (hdr_q.op == OP_MEMBER) && acc_member_q;
			res_mult_q    <= (hdr_q.op == OP_MULTI) ? MULT_W'(min_q) : '0;
		end
	end

endmodule

`default_nettype wire

>>> dv/tb.sv
// self-checking testbench of the counting bloom filter engine: directed rows, then random phases
module tb;
	import cbf_pkg::*;

	localparam int NCNT      = 4096;
	localparam int MAX_HASH  = 8;
	localparam int MAX_CBITS = 8;
	localparam int POOL_SZ   = 24;
	localparam int PHASES    = 10;
	localparam int PHASE_LEN = 160;
	localparam int HOLD_LEN  = 400;

	// one result beat as seen on the output ports
	typedef struct packed {
		logic              success;
		logic              member;
		logic [MULT_W-1:0] mult;
	} result_t;

	typedef logic [LANES-1:0][IDX_W-1:0] lanes_t;

	// one row of the directed part; want is used only when known is set
	typedef struct packed {
		op_t     op;
		lanes_t  idx;
		logic    known;
		result_t want;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_stall;
	logic [OP_W-1:0]      opcode;
	logic [IDX_W-1:0]     index_0, index_1, index_2, index_3;
	logic [IDX_W-1:0]     index_4, index_5, index_6, index_7;
	logic                 out_valid;
	logic                 out_stall;
	logic                 success;
	logic                 member;
	logic [MULT_W-1:0]    multiplicity;

	// shadow of the counter store and of the two registers
	logic [7:0]       cnt_mem [NCNT];
	logic [CFG_W-1:0] cur_cbits;
	logic [CFG_W-1:0] cur_hcnt;

	// results still owed by the block, oldest first
	result_t pending_q[$];

	lanes_t pool [POOL_SZ];
	int     err_cnt;
	bit     hold_req;   // asks the receiver for one long hold-off
	bit     calm;       // no idling on either side

	counting_bloom_filter_engine_unit #(
		.NUM_COUNTERS     (NCNT),
		.MAX_HASHES       (MAX_HASH),
		.MAX_COUNTER_BITS (MAX_CBITS)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.opcode       (opcode),
		.index_0      (index_0),
		.index_1      (index_1),
		.index_2      (index_2),
		.index_3      (index_3),
		.index_4      (index_4),
		.index_5      (index_5),
		.index_6      (index_6),
		.index_7      (index_7),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.success      (success),
		.member       (member),
		.multiplicity (multiplicity)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// applies one request to the shadow store and returns the beat it causes
	function automatic result_t apply_request(op_t op, lanes_t idx);
		int      bits, n, limit, cur, minv, i, j;
		int      pos [LANES];
		int      val [LANES];
		bit      ok, all_set;
		result_t r;
		// out-of-range register values clamp to the usable range
		bits = (cur_cbits == 0) ? 1
			: ((int'(cur_cbits) > MAX_CBITS) ? MAX_CBITS : int'(cur_cbits));
		n = (cur_hcnt == 0) ? 1 : ((int'(cur_hcnt) > MAX_HASH) ? MAX_HASH : int'(cur_hcnt));
		limit = (1 << bits) - 1;
		r = '0;
		ok = 1'b1;
		all_set = 1'b1;
		minv = 32'h7fff_ffff;
		// a counter reads as the low bits of its word, so a narrowed width hides the rest
		for (i = 0; i < n; i++) begin
			pos[i] = int'(idx[i]) % NCNT;
			val[i] = cnt_mem[pos[i]] & limit;
		end
		if (op == OP_INSERT || op == OP_DELETE) begin
			// a repeated position sees the value left by its earlier occurrence
			for (i = 0; i < n && ok; i++) begin
				cur = val[i];
				for (j = 0; j < i; j++)
					if (pos[j] == pos[i])
						cur = val[j];
				if (op == OP_INSERT) begin
					if (cur >= limit)
						ok = 1'b0;
					else
						val[i] = cur + 1;
				end else begin
					if (cur == 0)
						ok = 1'b0;
					else
						val[i] = cur - 1;
				end
			end
			// all or nothing; the last occurrence of a position carries its final value
			if (ok)
				for (i = 0; i < n; i++)
					cnt_mem[pos[i]] = 8'(val[i]);
			r.success = ok;
		end else begin
			for (i = 0; i < n; i++) begin
				if (val[i] == 0)
					all_set = 1'b0;
				if (val[i] < minv)
					minv = val[i];
			end
			if (op == OP_MEMBER)
				r.member = all_set;
			else
				r.mult = minv[MULT_W-1:0];
		end
		return r;
	endfunction

	// directed row over the first four lanes; the upper lanes carry junk that hash_count hides
	function automatic dir_row_t mk(op_t op, int a, int b, int c, int d, bit known = 1'b0,
			bit s = 1'b0, bit m = 1'b0, int mult = 0);
		dir_row_t row;
		row.op = op;
		row.idx = {12'h5A5, 12'hA5A, 12'h000, 12'hFFF,
			IDX_W'(d), IDX_W'(c), IDX_W'(b), IDX_W'(a)};
		row.known = known;
		row.want.success = s;
		row.want.member = m;
		row.want.mult = MULT_W'(mult);
		return row;
	endfunction

	// idle length for either side: mostly none or short, now and then long
	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		err_cnt++;
		if (err_cnt <= 40)
			$display("mismatch %0s: got %0d, expected %0d at %0t", what, got, want, $time);
	endtask

	// offers one request beat, waits for it to be taken and books its result
	task automatic send_req(op_t op, lanes_t idx, bit known, result_t want);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		index_0 <= idx[0];
		index_1 <= idx[1];
		index_2 <= idx[2];
		index_3 <= idx[3];
		index_4 <= idx[4];
		index_5 <= idx[5];
		index_6 <= idx[6];
		index_7 <= idx[7];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// the shadow store moves even where the expected beat is typed in
		if (known) begin
			void'(apply_request(op, idx));
			pending_q.push_back(want);
		end else begin
			pending_q.push_back(apply_request(op, idx));
		end
	endtask

	// waits until every booked result has come out, then lets the pipeline settle
	task automatic drain();
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// register writes only on an idle block
	task automatic write_cfg(logic [CFG_W-1:0] cbits, logic [CFG_W-1:0] hcnt);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_COUNTER_BITS;
		cfg_data <= cbits;
		@(posedge clk);
		cur_cbits = cbits;
		cfg_index <= CFG_HASH_COUNT;
		cfg_data <= hcnt;
		@(posedge clk);
		cur_hcnt = hcnt;
		cfg_wr_en <= 1'b0;
	endtask

	// receiver: random stall runs, free stretches, and one long hold-off on request
	initial begin : rx_stall
		int len;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req) begin
				// long hold-off so the command queue and result register fill up
				out_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
				hold_req = 1'b0;
			end
			out_stall <= 1'b0;
			len = calm ? 20 : (($urandom_range(0, 9) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12));
			repeat (len) @(posedge clk);
			if (!calm && !hold_req) begin
				out_stall <= 1'b1;
				len = idle_len();
				if (len == 0)
					len = 1;
				repeat (len) @(posedge clk);
			end
		end
	end

	// result side: every accepted beat is matched against the oldest booked one
	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result beat", 1, 0);
			end else begin
				want = pending_q.pop_front();
				if (success !== want.success)
					report_mismatch("success", success, want.success);
				if (member !== want.member)
					report_mismatch("member", member, want.member);
				if (multiplicity !== want.mult)
					report_mismatch("multiplicity", multiplicity, want.mult);
			end
		end
	end

	initial begin : stim
		dir_row_t         dir_rows[$];
		lanes_t           idx;
		op_t              op;
		int               r, e, k;
		result_t          none;
		logic [CFG_W-1:0] cb_plan [PHASES];
		logic [CFG_W-1:0] hc_plan [PHASES];

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_COUNTER_BITS;
		cfg_data = '0;
		in_valid = 1'b0;
		opcode = OP_INSERT;
		{index_0, index_1, index_2, index_3} = '0;
		{index_4, index_5, index_6, index_7} = '0;
		err_cnt = 0;
		hold_req = 1'b0;
		calm = 1'b0;
		cur_cbits = 4'd4;
		cur_hcnt = 4'd4;
		none = '0;
		for (k = 0; k < NCNT; k++)
			cnt_mem[k] = 8'd0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at the reset settings: 4-bit counters, four lanes
		// empty store: queries see zero, a delete underflows
		dir_rows.push_back(mk(OP_MEMBER, 0, 4095, 1, 2, 1, 0, 0, 0));
		dir_rows.push_back(mk(OP_MULTI,  0, 4095, 1, 2, 1, 0, 0, 0));
		dir_rows.push_back(mk(OP_DELETE, 0, 4095, 1, 2, 1, 0, 0, 0));
		// extremes of the index range
		dir_rows.push_back(mk(OP_INSERT, 0, 4095, 1, 2, 1, 1, 0, 0));
		dir_rows.push_back(mk(OP_MEMBER, 0, 4095, 1, 2, 1, 0, 1, 0));
		dir_rows.push_back(mk(OP_MULTI,  0, 4095, 1, 2, 1, 0, 0, 1));
		dir_rows.push_back(mk(OP_MEMBER, 0, 4095, 1, 3, 1, 0, 0, 0));
		// repeated position counts each time, up to saturation
		dir_rows.push_back(mk(OP_INSERT, 7, 7, 7, 7, 1, 1, 0, 0));
		dir_rows.push_back(mk(OP_INSERT, 7, 7, 7, 7, 1, 1, 0, 0));
		dir_rows.push_back(mk(OP_INSERT, 7, 7, 7, 7, 1, 1, 0, 0));
		dir_rows.push_back(mk(OP_INSERT, 7, 7, 7, 7, 1, 0, 0, 0));
		dir_rows.push_back(mk(OP_MULTI,  7, 7, 7, 7, 1, 0, 0, 12));
		dir_rows.push_back(mk(OP_INSERT, 7, 7, 7, 8, 1, 1, 0, 0));
		dir_rows.push_back(mk(OP_INSERT, 7, 8, 9, 10, 1, 0, 0, 0));
		dir_rows.push_back(mk(OP_MULTI,  7, 8, 7, 8));
		// repeated position running a counter below zero
		dir_rows.push_back(mk(OP_DELETE, 8, 8, 9, 10, 1, 0, 0, 0));
		dir_rows.push_back(mk(OP_DELETE, 7, 8, 0, 4095, 1, 1, 0, 0));
		dir_rows.push_back(mk(OP_MEMBER, 7, 1, 2, 3));
		dir_rows.push_back(mk(OP_DELETE, 1, 2, 1, 2));
		dir_rows.push_back(mk(OP_MULTI,  4095, 4095, 4095, 4095));
		dir_rows.push_back(mk(OP_INSERT, 4095, 4095, 4095, 4095));
		dir_rows.push_back(mk(OP_DELETE, 7, 7, 7, 7));
		dir_rows.push_back(mk(OP_MULTI,  7, 1, 1, 7));
		foreach (dir_rows[i])
			send_req(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].known, dir_rows[i].want);
		in_valid <= 1'b0;

		// element pool: hash positions crowd a small region so counters collide and saturate
		for (e = 0; e < POOL_SZ; e++)
			for (k = 0; k < LANES; k++) begin
				if (k > 0 && $urandom_range(0, 9) == 0)
					pool[e][k] = pool[e][$urandom_range(0, k - 1)];
				else if ($urandom_range(0, 1) == 0)
					pool[e][k] = IDX_W'($urandom_range(0, 31));
				else
					pool[e][k] = IDX_W'($urandom_range(0, 4095));
			end

		// register settings per phase, extremes and out-of-range values among them;
		// the store is never cleared, so width changes act on live counters
		cb_plan = '{4'd1, 4'd8, 4'd8, 4'd0, 4'd15, 4'd2, 4'd3, 4'd5, 4'd6, 4'd4};
		hc_plan = '{4'd8, 4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2, 4'd7, 4'd4};

		for (int ph = 0; ph < PHASES; ph++) begin
			write_cfg(cb_plan[ph], hc_plan[ph]);
			calm = (ph == 3 || ph == 7);
			if (ph == 1)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_LEN; n++) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					// request on a known element
					idx = pool[$urandom_range(0, POOL_SZ - 1)];
					r = $urandom_range(0, 99);
					op = (r < 35) ? OP_INSERT : (r < 60) ? OP_DELETE
						: (r < 80) ? OP_MEMBER : OP_MULTI;
					// now and then one position is off
					if ($urandom_range(0, 19) == 0)
						idx[$urandom_range(0, LANES - 1)] = IDX_W'($urandom_range(0, 4095));
				end else begin
					// noise over the whole field range
					op = op_t'($urandom_range(0, 3));
					for (k = 0; k < LANES; k++)
						idx[k] = IDX_W'($urandom_range(0, 4095));
				end
				send_req(op, idx, 1'b0, none);
			end
			in_valid <= 1'b0;
		end

		drain();
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog, several times the slowest legal run including the clearing pass
	initial begin
		#8_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
